// ----- rtl/ild_pkg.sv -----
// ----------------------------------------------------------------------------
// ild_pkg
// Shared types, codes and helpers for the x86 instruction length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ild_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 4;

  typedef enum logic [2:0] {
    KIND_NORMAL = 3'd0,
    KIND_JUMP   = 3'd1,
    KIND_COND   = 3'd2,
    KIND_CALL   = 3'd3,
    KIND_IJUMP  = 3'd4,
    KIND_ICALL  = 3'd5,
    KIND_RET    = 3'd6
  } kind_e;

  typedef struct packed {
    logic [LenW-1:0]  len;
    kind_e            kind;
    logic [3:0]       cond;
    logic             branch;
    logic [AddrW-1:0] disp;
  } dec_t;

  // ModR/M plus SIB plus displacement byte count, 1..6
  function automatic logic [2:0] modrm_len(input logic [7:0] modrm, input logic [7:0] sib);
    logic [1:0] md;
    logic [2:0] rm;
    logic [2:0] n;
    md = modrm[7:6];
    rm = modrm[2:0];
    n  = 3'd1;
    if (md != 2'd3) begin
      if (rm == 3'd4) begin
        n = n + 3'd1;
        if (sib[2:0] == 3'd5 && md == 2'd0) n = n + 3'd4;
      end else if (rm == 3'd5 && md == 2'd0) begin
        n = n + 3'd4;
      end
      if (md == 2'd1) n = n + 3'd1;
      else if (md == 2'd2) n = n + 3'd4;
    end
    return n;
  endfunction

  function automatic logic alu_rm(input logic [7:0] op);
    return (op < 8'h40) && (op[2:0] <= 3'd3);
  endfunction

  function automatic logic alu_i8(input logic [7:0] op);
    return (op < 8'h40) && (op[2:0] == 3'd4);
  endfunction

  function automatic logic alu_iw(input logic [7:0] op);
    return (op < 8'h40) && (op[2:0] == 3'd5);
  endfunction

  function automatic logic rm_common(input logic [7:0] op);
    return alu_rm(op) || (op inside {8'h84, 8'h85, [8'h88:8'h8b], 8'hd0, 8'hd1, 8'hd3});
  endfunction

  function automatic logic rm_imm8(input logic [7:0] op);
    return op inside {8'h6b, 8'h80, 8'h83, 8'hc0, 8'hc1, 8'hc6};
  endfunction

  function automatic logic rm_immw(input logic [7:0] op);
    return op inside {8'h69, 8'h81, 8'hc7};
  endfunction

  function automatic logic [LenW-1:0] ext_len(input logic [2:0] v);
    return {{(LenW-3){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ild_decode.sv -----
// ----------------------------------------------------------------------------
// ild_decode
// Stage 1: opcode map walk, length, kind, condition and displacement select.
// ----------------------------------------------------------------------------
`default_nettype none

module ild_decode (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [ild_pkg::AddrW-1:0] addr_i,
  input  wire logic [7:0]                b0_i,
  input  wire logic [7:0]                b1_i,
  input  wire logic [7:0]                b2_i,
  input  wire logic [7:0]                b3_i,
  input  wire logic [7:0]                b4_i,
  input  wire logic [7:0]                b5_i,
  output logic                           valid_o,
  output logic [ild_pkg::AddrW-1:0]      addr_o,
  output ild_pkg::dec_t                  dec_o
);
  import ild_pkg::*;

  logic       valid_q;
  logic [AddrW-1:0] addr_q;
  dec_t       dec_d, dec_q;
  logic [2:0] r12, r23, r34, r45;
  logic [2:0] reg_f;
  logic [7:0] op, op1;

  assign r12   = modrm_len(b1_i, b2_i);
  assign r23   = modrm_len(b2_i, b3_i);
  assign r34   = modrm_len(b3_i, b4_i);
  assign r45   = modrm_len(b4_i, b5_i);
  assign reg_f = b1_i[5:3];
  assign op    = b0_i;
  assign op1   = b1_i;

  always_comb begin
    dec_d        = '0;
    dec_d.kind   = KIND_NORMAL;
    if ((op inside {[8'h40:8'h5f], 8'h90, 8'h98, 8'h99, 8'hc9, 8'hfc, 8'hfd})) begin
      dec_d.len = 4'd1;
    end else if (alu_i8(op) || (op inside {8'h6a, 8'ha8, [8'hb0:8'hb7], 8'hf3})) begin
      dec_d.len = 4'd2;
    end else if (alu_iw(op) || (op inside {8'h68, [8'ha0:8'ha3], 8'ha9, [8'hb8:8'hbf]})) begin
      dec_d.len = 4'd5;
    end else if (rm_common(op) || (op inside {8'h8d, 8'h8f, 8'hfe})) begin
      dec_d.len = 4'd1 + ext_len(r12);
    end else if (rm_imm8(op)) begin
      dec_d.len = 4'd2 + ext_len(r12);
    end else if (rm_immw(op)) begin
      dec_d.len = 4'd5 + ext_len(r12);
    end else if (op inside {[8'h70:8'h7f]}) begin
      dec_d.len    = 4'd2;
      dec_d.kind   = KIND_COND;
      dec_d.cond   = op[3:0];
      dec_d.branch = 1'b1;
      dec_d.disp   = {{(AddrW-8){b1_i[7]}}, b1_i};
    end else if (op == 8'hc3) begin
      dec_d.len  = 4'd1;
      dec_d.kind = KIND_RET;
    end else if (op == 8'he8 || op == 8'he9) begin
      dec_d.len    = 4'd5;
      dec_d.kind   = (op == 8'he8) ? KIND_CALL : KIND_JUMP;
      dec_d.branch = 1'b1;
      dec_d.disp   = {b4_i, b3_i, b2_i, b1_i};
    end else if (op == 8'heb) begin
      dec_d.len    = 4'd2;
      dec_d.kind   = KIND_JUMP;
      dec_d.branch = 1'b1;
      dec_d.disp   = {{(AddrW-8){b1_i[7]}}, b1_i};
    end else if (op == 8'hf2) begin
      if (b1_i == 8'h0f && (b2_i == 8'h10 || b2_i == 8'h11)) dec_d.len = 4'd3 + ext_len(r34);
    end else if (op == 8'hf6) begin
      dec_d.len = 4'd1 + ext_len(r12) + ((reg_f == 3'd0) ? 4'd1 : 4'd0);
    end else if (op == 8'hf7) begin
      dec_d.len = 4'd1 + ext_len(r12) + ((reg_f == 3'd0) ? 4'd4 : 4'd0);
    end else if (op == 8'hff) begin
      dec_d.len = 4'd1 + ext_len(r12);
      if (reg_f == 3'd2) dec_d.kind = KIND_ICALL;
      else if (reg_f == 3'd4) dec_d.kind = KIND_IJUMP;
    end else if (op == 8'h0f) begin
      // 0F map: ModR/M at byte two
      if (op1 == 8'h31) begin
        dec_d.len = 4'd2;
      end else if (op1 inside {8'h1f, 8'h29, [8'h40:8'h4f], [8'h90:8'h9f], 8'ha3, 8'ha5,
                               8'had, 8'haf, 8'hb6, 8'hb7, 8'hbd, 8'hbe, 8'hbf}) begin
        dec_d.len = 4'd2 + ext_len(r23);
      end else if (op1 inside {8'ha4, 8'hac, 8'hba}) begin
        dec_d.len = 4'd3 + ext_len(r23);
      end else if (op1 inside {[8'h80:8'h8f]}) begin
        dec_d.len    = 4'd6;
        dec_d.kind   = KIND_COND;
        dec_d.cond   = op1[3:0];
        dec_d.branch = 1'b1;
        dec_d.disp   = {b5_i, b4_i, b3_i, b2_i};
      end
    end else if (op == 8'h66) begin
      // operand size prefix map
      if ((op1 inside {[8'h40:8'h4f], 8'h90})) begin
        dec_d.len = 4'd2;
      end else if (alu_i8(op1) || (op1 inside {8'ha8, [8'hb0:8'hb7]})) begin
        dec_d.len = 4'd3;
      end else if (alu_iw(op1) || (op1 inside {8'ha9, [8'hb8:8'hbf]})) begin
        dec_d.len = 4'd4;
      end else if (op1 == 8'ha1 || op1 == 8'ha3) begin
        dec_d.len = 4'd6;
      end else if (rm_common(op1)) begin
        dec_d.len = 4'd2 + ext_len(r23);
      end else if (rm_imm8(op1)) begin
        dec_d.len = 4'd3 + ext_len(r23);
      end else if (rm_immw(op1)) begin
        dec_d.len = 4'd4 + ext_len(r23);
      end else if (op1 == 8'h0f) begin
        if (b2_i inside {8'h1f, [8'h40:8'h4f], 8'haf, 8'hef}) dec_d.len = 4'd3 + ext_len(r34);
      end else if (op1 == 8'hf7) begin
        dec_d.len = 4'd2 + ext_len(r23) + ((b2_i[5:3] == 3'd0) ? 4'd2 : 4'd0);
      end else if (op1 == 8'hff) begin
        dec_d.len = 4'd2 + ext_len(r23);
      end else if (op1 == 8'h2e) begin
        if (b2_i == 8'h0f && b3_i == 8'h1f) dec_d.len = 4'd4 + ext_len(r45);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dec_q  <= dec_d;
      addr_q <= addr_i;
    end
  end

  assign valid_o = valid_q;
  assign addr_o  = addr_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

// ----- rtl/ild_target.sv -----
// ----------------------------------------------------------------------------
// ild_target
// Stages 2 and 3: address plus length, then plus displacement; result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module ild_target (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic [ild_pkg::AddrW-1:0]  addr_i,
  input  wire ild_pkg::dec_t              dec_i,
  output logic                            valid_o,
  output logic [ild_pkg::LenW-1:0]        length_o,
  output logic [2:0]                      kind_o,
  output logic [3:0]                      condition_o,
  output logic [ild_pkg::AddrW-1:0]       destination_o,
  output logic                            unsupported_o
);
  import ild_pkg::*;

  logic             v2_q, v3_q;
  dec_t             dec2_q;
  logic [AddrW-1:0] sum2_q;
  logic [LenW-1:0]  len3_q;
  kind_e            kind3_q;
  logic [3:0]       cond3_q;
  logic [AddrW-1:0] dest3_d, dest3_q;
  logic             unsup3_q;

  assign dest3_d = dec2_q.branch ? (sum2_q + dec2_q.disp) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dec2_q <= dec_i;
      sum2_q <= addr_i + {{(AddrW-LenW){1'b0}}, dec_i.len};
    end
    if (v2_q) begin
      len3_q   <= dec2_q.len;
      kind3_q  <= dec2_q.kind;
      cond3_q  <= dec2_q.cond;
      dest3_q  <= dest3_d;
      unsup3_q <= (dec2_q.len == '0);
    end
  end

  assign valid_o       = v3_q;
  assign length_o      = len3_q;
  assign kind_o        = unsup3_q ? KIND_NORMAL : kind3_q;
  assign condition_o   = unsup3_q ? 4'd0 : cond3_q;
  assign destination_o = unsup3_q ? '0 : dest3_q;
  assign unsupported_o = unsup3_q;

  a_unsup_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (unsupported_o == (length_o == '0)))
    else $error("unsupported flag disagrees with length");

  a_dest_nonbranch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o != KIND_JUMP && kind_o != KIND_COND && kind_o != KIND_CALL
      |-> destination_o == '0)
    else $error("destination set for a non-branch item");

  a_cond_only_jcc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o != KIND_COND |-> condition_o == 4'd0)
    else $error("condition set outside conditional jump");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, 2))
    else $error("result without an item two stages back");

endmodule

`default_nettype wire

// ----- rtl/x86_instruction_length_decoder_core.sv -----
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_core
// Length, branch kind and direct target of a 32-bit x86 instruction.
//
//   channel | ports                                         | handshake
//   --------+-----------------------------------------------+---------------
//   item in | instruction_address_i, byte_zero_i..byte_five_i | start_i, busy_o
//   result  | length_o, kind_o, condition_o, destination_o,  | valid_o strobe
//           | unsupported_o                                  |
//
// Three register stages: decode, address plus length, plus displacement.
// One item per cycle; busy_o is always low.
// valid_o is high for one cycle per item, in order.
// rst_ni clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_instruction_length_decoder_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [ild_pkg::AddrW-1:0] instruction_address_i,
  input  wire logic [7:0]                byte_zero_i,
  input  wire logic [7:0]                byte_one_i,
  input  wire logic [7:0]                byte_two_i,
  input  wire logic [7:0]                byte_three_i,
  input  wire logic [7:0]                byte_four_i,
  input  wire logic [7:0]                byte_five_i,
  output logic                           valid_o,
  output logic [ild_pkg::LenW-1:0]       length_o,
  output logic [2:0]                     kind_o,
  output logic [3:0]                     condition_o,
  output logic [ild_pkg::AddrW-1:0]      destination_o,
  output logic                           unsupported_o
);
  import ild_pkg::*;

  logic             s1_valid;
  logic [AddrW-1:0] s1_addr;
  dec_t             s1_dec;

  assign busy_o = 1'b0;

  ild_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .addr_i  (instruction_address_i),
    .b0_i    (byte_zero_i),
    .b1_i    (byte_one_i),
    .b2_i    (byte_two_i),
    .b3_i    (byte_three_i),
    .b4_i    (byte_four_i),
    .b5_i    (byte_five_i),
    .valid_o (s1_valid),
    .addr_o  (s1_addr),
    .dec_o   (s1_dec)
  );

  ild_target u_target (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s1_valid),
    .addr_i        (s1_addr),
    .dec_i         (s1_dec),
    .valid_o       (valid_o),
    .length_o      (length_o),
    .kind_o        (kind_o),
    .condition_o   (condition_o),
    .destination_o (destination_o),
    .unsupported_o (unsupported_o)
  );

endmodule

`default_nettype wire
